### design/sida_pkg.sv
`timescale 1ns / 1ps
package sida_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int TEXT_BITS = 6;
	localparam int DIGIT_BITS = 4;

	localparam logic [TEXT_BITS-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [TEXT_BITS-1:0] CHAR_MINUS = 6'd45;

	typedef struct packed {
		logic clr;
		logic dabble;
		logic bit_in;
		logic shift_digit;
	} sida_bcd_ctrl_t;

endpackage

### design/sida_if.sv
`timescale 1ns / 1ps
interface sida_num_if import sida_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface sida_text_if import sida_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [TEXT_BITS-1:0] text_char;
	logic                 last_char;

	modport source (output valid, output text_char, output last_char, input ready);
	modport sink (input valid, input text_char, input last_char, output ready);
endinterface

### design/sida_bcd_reg.sv
`timescale 1ns / 1ps
module sida_bcd_reg import sida_pkg::*; #(
	parameter int NDIG = 10
) (
	input  logic                  clk,
	input  sida_bcd_ctrl_t        ctrl,
	output logic [DIGIT_BITS-1:0] top_digit
);

	localparam int W = NDIG * DIGIT_BITS;

	logic [W-1:0] bcd_q;
	logic [W-1:0] adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
				adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_q[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
			end else begin
				adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_q[i*DIGIT_BITS +: DIGIT_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			bcd_q <= '0;
		end else if (ctrl.dabble) begin
			bcd_q <= {adj[W-2:0], ctrl.bit_in};
		end else if (ctrl.shift_digit) begin
			bcd_q <= {bcd_q[W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
		end
	end

	assign top_digit = bcd_q[W-1 -: DIGIT_BITS];

endmodule

### design/signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// Converts one signed VALUE_BITS-bit integer per item into its decimal ASCII
// text, most significant character first: an optional '-', then the digits
// with leading zeros dropped ('0' for zero), last_char set on the final one.
// The most negative value converts exactly. An item is accepted, then fed
// one bit per cycle through a shift-and-add-3 BCD register; then leading
// zero digits are dropped and the text is sent, a '-' first for a negative
// value, then one digit per cycle while text does not stall. Stalls on text
// lengthen the character phase. The output register lets a new item be
// accepted while the last character waits.
module signed_int_to_decimal_ascii_core import sida_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	sida_num_if.sink          number,
	sida_text_if.source       text
);

	localparam int NDIG = (VALUE_BITS * 302) / 1000 + 1;
	localparam int CW   = $clog2(VALUE_BITS);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CONV  = 5'b00010,
		S_SKIP  = 5'b00100,
		S_SIGN  = 5'b01000,
		S_DIGIT = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   bin_q;
	logic [CW-1:0]           cnt_q;
	logic                    neg_q;
	logic                    out_valid_q;
	logic [TEXT_BITS-1:0]    text_q;
	logic                    last_q;

	sida_bcd_ctrl_t          bcd_ctrl;
	logic [DIGIT_BITS-1:0]   top_digit;
	logic                    accept;
	logic                    slot_free;
	logic                    emit;
	logic                    v_neg;

	assign accept    = number.valid && number.ready;
	assign slot_free = !out_valid_q || text.ready;
	assign emit      = slot_free && ((state_q == S_SIGN) || (state_q == S_DIGIT));
	assign v_neg     = number.value[VALUE_BITS-1];

	assign number.ready   = arst_n && (state_q == S_IDLE);
	assign text.valid     = out_valid_q;
	assign text.text_char = text_q;
	assign text.last_char = last_q;

	always_comb begin
		bcd_ctrl.clr         = accept;
		bcd_ctrl.dabble      = (state_q == S_CONV);
		bcd_ctrl.bit_in      = bin_q[VALUE_BITS-1];
		bcd_ctrl.shift_digit = ((state_q == S_SKIP) && (top_digit == '0) && (cnt_q != '0))
			|| ((state_q == S_DIGIT) && slot_free);
	end

	sida_bcd_reg #(.NDIG(NDIG)) u_bcd (
		.clk       (clk),
		.ctrl      (bcd_ctrl),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= v_neg ? (~number.value + 1'b1) : number.value;
		end else if (state_q == S_CONV) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			text_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (text.ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						neg_q   <= v_neg;
						cnt_q   <= CW'(VALUE_BITS - 1);
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (cnt_q == '0) begin
						cnt_q   <= CW'(NDIG - 1);
						state_q <= S_SKIP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SKIP: begin
					if ((top_digit == '0) && (cnt_q != '0)) begin
						cnt_q <= cnt_q - 1'b1;
					end else begin
						state_q <= neg_q ? S_SIGN : S_DIGIT;
					end
				end
				S_SIGN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						text_q      <= CHAR_MINUS;
						last_q      <= 1'b0;
						state_q     <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						text_q      <= CHAR_ZERO + TEXT_BITS'(top_digit);
						last_q      <= (cnt_q == '0);
						if (cnt_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import sida_pkg::*;

	localparam int VB = VALUE_BITS_DEF;

	typedef struct packed {
		logic [TEXT_BITS-1:0] text_char;
		logic                 last_char;
	} text_item_t;

	class text_scoreboard;
		text_item_t expected_chars[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// decimal text of one number: optional minus, digits MSD first
		function void note_number(logic signed [VB-1:0] value);
			logic          neg;
			logic [VB:0]   mag;
			logic [3:0]    digits[$];
			text_item_t    ch;
			neg = value[VB-1];
			mag = neg ? (~{1'b1, value} + 1'b1) : {1'b0, value};
			do begin
				digits.push_front(4'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
			if (neg) begin
				ch.text_char = CHAR_MINUS;
				ch.last_char = 1'b0;
				expected_chars.push_back(ch);
			end
			foreach (digits[i]) begin
				ch.text_char = CHAR_ZERO + TEXT_BITS'(digits[i]);
				ch.last_char = (i == digits.size() - 1);
				expected_chars.push_back(ch);
			end
		endfunction

		function void check_char(logic [TEXT_BITS-1:0] text_char, logic last_char);
			text_item_t want;
			if (expected_chars.size() == 0) begin
				$error("unexpected item: text_char=%0d last_char=%0d", text_char, last_char);
				errors++;
				return;
			end
			want = expected_chars.pop_front();
			if (text_char !== want.text_char) begin
				$error("text_char: expected %0d, got %0d", want.text_char, text_char);
				errors++;
			end
			if (last_char !== want.last_char) begin
				$error("last_char: expected %0d, got %0d", want.last_char, last_char);
				errors++;
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   tx_idle_en;
	bit   rx_stall_en;
	text_scoreboard sb;

	sida_num_if #(.VALUE_BITS(VB)) num_if ();
	sida_text_if                   txt_if ();

	signed_int_to_decimal_ascii_core #(.VALUE_BITS(VB)) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.number(num_if.sink),
		.text  (txt_if.source)
	);

	logic signed [VB-1:0] directed_values [22] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
		32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001, 32'sd1000000000,
		32'sd999999999, -32'sd999999999, 32'sd1234567890, -32'sd1234567890,
		32'sh55555555, 32'shAAAAAAAA, 32'sd42, -32'sd5, -32'sd1000000000,
		32'sd2000000000
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// mostly short, a few long
	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [VB-1:0] rand_number();
		int   sel;
		int   k;
		int   p;
		logic signed [VB-1:0] v;
		sel = $urandom_range(0, 3);
		p = 1;
		case (sel)
			0: begin
				v = $urandom;
			end
			1: begin
				v = $urandom_range(0, 999);
			end
			2: begin
				k = $urandom_range(0, 9);
				repeat (k) p = p * 10;
				v = p + $urandom_range(0, 2) - 1;
			end
			default: begin
				k = $urandom_range(1, 9);
				repeat (k) p = p * 10;
				v = $urandom_range(0, p - 1);
			end
		endcase
		if (sel != 0 && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	task automatic send_number(logic signed [VB-1:0] v);
		int gap;
		gap = (tx_idle_en && $urandom_range(0, 9) < 4) ? idle_len() : 0;
		if (gap > 0) begin
			num_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		num_if.valid <= 1'b1;
		num_if.value <= v;
		do @(posedge clk); while (!num_if.ready);
	endtask

	task automatic drain();
		num_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_random(int count);
		repeat (count) send_number(rand_number());
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (num_if.valid && num_if.ready)
				sb.note_number(num_if.value);
			if (txt_if.valid && txt_if.ready)
				sb.check_char(txt_if.text_char, txt_if.last_char);
		end
	end

	initial begin
		int stall_left;
		stall_left = 0;
		txt_if.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				txt_if.ready <= 1'b0;
				stall_left--;
			end else if (rx_stall_en && $urandom_range(0, 9) < 3) begin
				txt_if.ready <= 1'b0;
				stall_left = idle_len() - 1;
			end else begin
				txt_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		sb = new();
		tx_idle_en = 1'b0;
		rx_stall_en = 1'b0;
		arst_n <= 1'b0;
		num_if.valid <= 1'b0;
		num_if.value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_values[i])
			send_number(directed_values[i]);
		drain();

		tx_idle_en = 1'b1;
		rx_stall_en = 1'b1;
		send_random(100);
		tx_idle_en = 1'b0;
		rx_stall_en = 1'b0;
		send_random(60);
		drain();
		tx_idle_en = 1'b1;
		send_random(40);
		rx_stall_en = 1'b1;
		send_random(90);

		num_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### files.f
design/sida_pkg.sv
design/sida_if.sv
design/sida_bcd_reg.sv
design/signed_int_to_decimal_ascii_core.sv
tb/tb.sv
